@@ rtl/ppr_pkg.sv @@
// ----------------------------------------------------------------------------
// Printer port register package
// Shared codes, addresses and beat layouts for the printer port register block.
// ----------------------------------------------------------------------------
package ppr_pkg;

   // Request kinds carried in req_tuser.
   localparam logic [1:0] REQ_READ   = 2'd0;
   localparam logic [1:0] REQ_WRITE  = 2'd1;
   localparam logic [1:0] REQ_FINISH = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_8MHZ      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIP_SWITCH_ONE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIP_SWITCH_THREE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALTERNATE_MODEL = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CPU_IS_V30      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRINTER_PRESENT = 3'd5;

   // Port addresses.
   localparam logic [8:0] ADDR_LEGACY_DATA    = 9'h040;
   localparam logic [8:0] ADDR_LEGACY_STATUS  = 9'h042;
   localparam logic [8:0] ADDR_LEGACY_CONTROL = 9'h044;
   localparam logic [8:0] ADDR_IEEE_DATA      = 9'h140;
   localparam logic [8:0] ADDR_IEEE_STATUS    = 9'h141;
   localparam logic [8:0] ADDR_IEEE_CONTROL   = 9'h142;
   localparam logic [8:0] ADDR_IEEE_MODE      = 9'h149;
   localparam logic [8:0] ADDR_EXTENDED_B     = 9'h14b;
   localparam logic [8:0] ADDR_EXTENDED_D     = 9'h14d;
   localparam logic [8:0] ADDR_EXTENDED_E     = 9'h14e;

   // Byte values.
   localparam logic [7:0] SELECT_CODE       = 8'h11;
   localparam logic [7:0] UNMAPPED_READ     = 8'hff;
   localparam logic [7:0] LEGACY_STATUS_BASE = 8'h84;
   localparam logic [7:0] IEEE_STATUS_BASE  = 8'h88;
   localparam logic [7:0] EXTENDED_E_MASK   = 8'hfc;
   localparam logic [2:0] SELECT_RUN_LIMIT  = 3'd6;

   localparam int unsigned REQ_TDATA_W = 24;
   localparam int unsigned REQ_TUSER_W = 2;
   localparam int unsigned RSP_TDATA_W = 24;

   typedef struct packed {
      logic       clock_8mhz;
      logic [7:0] dip_switch_one;
      logic [7:0] dip_switch_three;
      logic       alternate_model;
      logic       cpu_is_v30;
      logic       printer_present;
   } cfg_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [8:0] io_address;
      logic [7:0] write_data;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       print_valid;
      logic [7:0] print_byte;
      logic       reopen;
   } result_type;

endpackage

@@ rtl/ppr_core.sv @@
// ----------------------------------------------------------------------------
// Printer port register core
// Holds the port registers and works out one bus access per cycle in which fire is high.
// ----------------------------------------------------------------------------
module ppr_core (
   input  logic                clock,
   input  logic                reset,
   input  ppr_pkg::cfg_type    cfg,
   input  logic                fire,
   input  ppr_pkg::item_type   item,
   output ppr_pkg::result_type result
);

   logic [7:0] legacy_last_byte_ff, legacy_last_byte_in;
   logic [7:0] legacy_control_ff, legacy_control_in;
   logic [2:0] select_run_count_ff, select_run_count_in;
   logic       select_busy_ff, select_busy_in;
   logic [7:0] ieee_data_ff, ieee_data_in;
   logic       ieee_not_ack_ff, ieee_not_ack_in;
   logic [7:0] ieee_control_ff, ieee_control_in;
   logic [7:0] ieee_mode_ff, ieee_mode_in;
   logic [7:0] extended_b_ff, extended_b_in;
   logic [7:0] extended_d_ff, extended_d_in;
   logic [7:0] extended_e_ff, extended_e_in;

   logic [7:0] legacy_status;
   logic [7:0] ieee_status;
   logic       is_read;
   logic       is_write;

   assign is_read  = (item.req_type == ppr_pkg::REQ_READ);
   assign is_write = (item.req_type == ppr_pkg::REQ_WRITE);

   always_comb begin
      legacy_status    = ppr_pkg::LEGACY_STATUS_BASE;
      legacy_status[5] = cfg.clock_8mhz;
      legacy_status[4] = cfg.dip_switch_one[2];
      legacy_status[3] = cfg.dip_switch_one[7];
      legacy_status[1] = cfg.alternate_model ? cfg.dip_switch_three[7] : cfg.cpu_is_v30;
      // A pending busy indication pulls the select bit low for one read.
      if (select_busy_ff) begin
         legacy_status[2] = 1'b0;
      end
      ieee_status    = ppr_pkg::IEEE_STATUS_BASE;
      ieee_status[6] = ieee_not_ack_ff;
      ieee_status[4] = ieee_control_ff[3] & cfg.printer_present;
   end

   always_comb begin
      legacy_last_byte_in = legacy_last_byte_ff;
      legacy_control_in   = legacy_control_ff;
      select_run_count_in = select_run_count_ff;
      select_busy_in      = select_busy_ff;
      ieee_data_in        = ieee_data_ff;
      ieee_not_ack_in     = ieee_not_ack_ff;
      ieee_control_in     = ieee_control_ff;
      ieee_mode_in        = ieee_mode_ff;
      extended_b_in       = extended_b_ff;
      extended_d_in       = extended_d_ff;
      extended_e_in       = extended_e_ff;
      result              = '0;

      if (is_read) begin
         case (item.io_address)
            ppr_pkg::ADDR_LEGACY_DATA:    result.read_data = legacy_last_byte_ff;
            ppr_pkg::ADDR_LEGACY_STATUS: begin
               result.read_data = legacy_status;
               select_busy_in   = 1'b0;
            end
            ppr_pkg::ADDR_LEGACY_CONTROL: result.read_data = legacy_control_ff;
            ppr_pkg::ADDR_IEEE_DATA:      result.read_data = ieee_data_ff;
            ppr_pkg::ADDR_IEEE_STATUS: begin
               result.read_data = ieee_status;
               ieee_not_ack_in  = 1'b1;
            end
            ppr_pkg::ADDR_IEEE_CONTROL:   result.read_data = ieee_control_ff;
            ppr_pkg::ADDR_IEEE_MODE:      result.read_data = ieee_mode_ff;
            ppr_pkg::ADDR_EXTENDED_B:     result.read_data = extended_b_ff;
            ppr_pkg::ADDR_EXTENDED_D:     result.read_data = extended_d_ff;
            ppr_pkg::ADDR_EXTENDED_E:     result.read_data = extended_e_ff;
            default:                      result.read_data = ppr_pkg::UNMAPPED_READ;
         endcase
      end else if (is_write) begin
         case (item.io_address)
            ppr_pkg::ADDR_LEGACY_DATA: begin
               result.print_valid  = 1'b1;
               result.print_byte   = item.write_data;
               legacy_last_byte_in = item.write_data;
               if (item.write_data == ppr_pkg::SELECT_CODE) begin
                  if (select_run_count_ff >= ppr_pkg::SELECT_RUN_LIMIT) begin
                     select_busy_in = 1'b1;
                  end else begin
                     select_run_count_in = select_run_count_ff + 3'd1;
                  end
               end else begin
                  select_run_count_in = '0;
               end
            end
            ppr_pkg::ADDR_LEGACY_CONTROL: legacy_control_in = item.write_data;
            ppr_pkg::ADDR_IEEE_DATA:      ieee_data_in = item.write_data;
            ppr_pkg::ADDR_IEEE_CONTROL: begin
               // Rising STROBE sends the data register; falling INIT reopens.
               if (!ieee_control_ff[0] && item.write_data[0]) begin
                  result.print_valid = 1'b1;
                  result.print_byte  = ieee_data_ff;
                  ieee_not_ack_in    = 1'b0;
               end
               result.reopen   = ieee_control_ff[2] & ~item.write_data[2] &
                                 cfg.printer_present;
               ieee_control_in = item.write_data;
            end
            ppr_pkg::ADDR_IEEE_MODE:  ieee_mode_in = item.write_data;
            ppr_pkg::ADDR_EXTENDED_B: extended_b_in = item.write_data;
            ppr_pkg::ADDR_EXTENDED_D: extended_d_in = item.write_data;
            ppr_pkg::ADDR_EXTENDED_E: begin
               extended_e_in = (item.write_data & ppr_pkg::EXTENDED_E_MASK) |
                               (extended_e_ff & ~ppr_pkg::EXTENDED_E_MASK);
            end
            default: ;
         endcase
      end else if (item.req_type == ppr_pkg::REQ_FINISH) begin
         result.reopen = cfg.printer_present;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         legacy_last_byte_ff <= 8'hff;
         legacy_control_ff   <= 8'h00;
         select_run_count_ff <= '0;
         select_busy_ff      <= 1'b0;
         ieee_data_ff        <= 8'hff;
         ieee_not_ack_ff     <= 1'b0;
         ieee_control_ff     <= 8'h00;
         ieee_mode_ff        <= 8'h00;
         extended_b_ff       <= 8'hff;
         extended_d_ff       <= 8'h00;
         extended_e_ff       <= 8'h01;
      end else if (fire) begin
         legacy_last_byte_ff <= legacy_last_byte_in;
         legacy_control_ff   <= legacy_control_in;
         select_run_count_ff <= select_run_count_in;
         select_busy_ff      <= select_busy_in;
         ieee_data_ff        <= ieee_data_in;
         ieee_not_ack_ff     <= ieee_not_ack_in;
         ieee_control_ff     <= ieee_control_in;
         ieee_mode_ff        <= ieee_mode_in;
         extended_b_ff       <= extended_b_in;
         extended_d_ff       <= extended_d_in;
         extended_e_ff       <= extended_e_in;
      end
   end

`ifndef SYNTHESIS
   a_run_count_bounded: assert property (@(posedge clock) disable iff (reset)
      select_run_count_ff <= ppr_pkg::SELECT_RUN_LIMIT)
      else $error("select run count went past its limit");

   a_busy_clears_on_status_read: assert property (@(posedge clock) disable iff (reset)
      fire && is_read && item.io_address == ppr_pkg::ADDR_LEGACY_STATUS |=> !select_busy_ff)
      else $error("busy indication survived a legacy status read");

   a_not_ack_set_on_status_read: assert property (@(posedge clock) disable iff (reset)
      fire && is_read && item.io_address == ppr_pkg::ADDR_IEEE_STATUS |=> ieee_not_ack_ff)
      else $error("not-ACK not set after an IEEE status read");

   a_reopen_needs_printer: assert property (@(posedge clock) disable iff (reset)
      fire && result.reopen |-> cfg.printer_present)
      else $error("reopen requested with no printer present");

   a_print_only_on_write: assert property (@(posedge clock) disable iff (reset)
      fire && result.print_valid |-> is_write)
      else $error("byte sent to the printer outside a write");
`endif

endmodule

@@ rtl/printer_port_registers.sv @@
// ----------------------------------------------------------------------------
// Printer port registers
// Legacy and IEEE parallel printer port register set behind a beat stream.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  req_      in         tuser: req_type; tdata: io_address, write_data
//  rsp_      out        tdata: read_data, print_valid, print_byte, reopen
//  csr_      in         write enable, register index, write data
//
// One beat is accepted per cycle while req_tready is high. An accepted beat
// enters the input register; its result beat is registered in the result
// register, and the decode logic sits between the input and result registers.
// Reset is synchronous and returns all port registers to their reset values.
// A stalled result beat holds in the result register while the input register
// still takes one more beat; after that req_tready drops until rsp_ drains.
// ----------------------------------------------------------------------------
module printer_port_registers (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: [8:0] io_address, [16:9] write_data, [23:17] zero
   input  logic [ppr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // tuser: [1:0] req_type
   input  logic [ppr_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: [7:0] read_data, [8] print_valid, [16:9] print_byte, [17] reopen,
   // [23:18] zero
   output logic [ppr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [ppr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ppr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   ppr_pkg::cfg_type    cfg_ff;
   ppr_pkg::item_type   item_ff;
   ppr_pkg::result_type result;
   ppr_pkg::result_type result_ff;
   logic                item_valid_ff;
   logic                rsp_valid_ff;
   logic                rsp_open;
   logic                fire;

   // The result register can take a beat when empty or draining this cycle.
   assign rsp_open   = !rsp_valid_ff || rsp_tready;
   assign fire       = item_valid_ff && rsp_open;
   assign req_tready = !item_valid_ff || rsp_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_8mhz       <= 1'b0;
         cfg_ff.dip_switch_one   <= 8'h00;
         cfg_ff.dip_switch_three <= 8'h00;
         cfg_ff.alternate_model  <= 1'b0;
         cfg_ff.cpu_is_v30       <= 1'b0;
         cfg_ff.printer_present  <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            ppr_pkg::CSR_CLOCK_8MHZ:       cfg_ff.clock_8mhz       <= csr_wdata[0];
            ppr_pkg::CSR_DIP_SWITCH_ONE:   cfg_ff.dip_switch_one   <= csr_wdata;
            ppr_pkg::CSR_DIP_SWITCH_THREE: cfg_ff.dip_switch_three <= csr_wdata;
            ppr_pkg::CSR_ALTERNATE_MODEL:  cfg_ff.alternate_model  <= csr_wdata[0];
            ppr_pkg::CSR_CPU_IS_V30:       cfg_ff.cpu_is_v30       <= csr_wdata[0];
            ppr_pkg::CSR_PRINTER_PRESENT:  cfg_ff.printer_present  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_tready) begin
            item_valid_ff <= req_tvalid;
         end
         if (rsp_open) begin
            rsp_valid_ff <= item_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.req_type   <= req_tuser;
         item_ff.io_address <= req_tdata[8:0];
         item_ff.write_data <= req_tdata[16:9];
      end
      if (fire) begin
         result_ff <= result;
      end
   end

   ppr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .fire   (fire),
      .item   (item_ff),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, result_ff.reopen, result_ff.print_byte,
                        result_ff.print_valid, result_ff.read_data};

endmodule
